/* rtl/core/mccl_pkg.sv */
package mccl_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LIMIT_MODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT_CURRENT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SAFE_CURRENT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SYS_RES       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DIODE_VOLTAGE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REDUCED_PORT  = 3'd5;

  // Limit modes
  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_CURRENT = 2'd1;
  localparam logic [1:0] MODE_FUSE    = 2'd2;

  localparam logic [6:0] CMD_MAG_MAX  = 7'd127;
  localparam int unsigned DivSteps    = 7;
  localparam int unsigned CntW        = $clog2(DivSteps);

  typedef struct packed {
    logic signed [15:0] current_filtered;
    logic signed [15:0] back_emf;
    logic        [15:0] winding_resistance;
    logic        [14:0] battery_voltage;
    logic signed [15:0] rpm;
    logic signed [7:0]  present_command;
    logic               ptc_tripped;
    logic               bank_ptc_tripped;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] command_limit;
    logic              no_limit;
    logic              trip_flag;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_NUM,
    ST_SCALE,
    ST_CMP,
    ST_DIV,
    ST_REDUCE,
    ST_STORE
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_MUL,
    DP_NUM,
    DP_SCALE,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_SET_ZERO,
    DP_SET_MAX,
    DP_REDUCE,
    DP_STORE_LIMIT,
    DP_STORE_NOLIMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_safe;
    logic   neg;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       mag_gt;
    logic       mag_lt_hyst;
    logic       lim_zero;
    logic       safe_zero;
    logic       cmd_neg;
    logic       rpm_neg;
    logic       rpm_pos;
    logic       ptc;
    logic       bank;
    logic       num_zero;
    logic       num_neg;
    logic       sat;
  } dp_stat_t;

endpackage

/* rtl/core/mccl_in_if.sv */
interface mccl_in_if import mccl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/mccl_out_if.sv */
interface mccl_out_if import mccl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/mccl_dpath.sv */
module mccl_dpath import mccl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_item_t            item_i,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  output logic signed [7:0]   limit_o,
  output logic                no_limit_o
);

  // Configuration
  logic [1:0]  mode_q;
  logic [14:0] lim_q;
  logic [14:0] safe_q;
  logic [15:0] sysres_q;
  logic [11:0] diode_q;
  logic        reduced_q;

  // Item fields
  logic signed [15:0] cur_q;
  logic signed [15:0] bemf_q;
  logic        [15:0] res_q;
  logic        [14:0] batt_q;
  logic signed [15:0] rpm_q;
  logic signed [7:0]  pcmd_q;
  logic               ptc_q;
  logic               bank_q;

  // Arithmetic
  logic        [31:0] prod_q, prod_d;
  logic        [25:0] den_q, den_d;
  logic signed [35:0] num_q, num_d;
  logic        [41:0] mag_q, mag_d;
  logic               neg_q;
  logic        [32:0] rem_q;
  logic        [31:0] dsh_q;
  logic        [6:0]  q_q, q_d;
  logic               sign_q;

  // Held limit
  logic signed [7:0]  held_limit_q;
  logic               held_nl_q;

  logic        [16:0] cur_mag;
  logic        [20:0] cur_mag10;
  logic        [20:0] lim9;
  logic        [14:0] tgt;
  logic        [16:0] rsum;
  logic        [15:0] bd_sum;
  logic        [33:0] drop;
  logic signed [35:0] bemf_k;
  logic signed [35:0] drop_s;
  logic        [34:0] abs_num;
  logic        [13:0] red_prod;
  logic        [7:0]  q_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NONE;
      lim_q     <= '0;
      safe_q    <= '0;
      sysres_q  <= '0;
      diode_q   <= '0;
      reduced_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LIMIT_MODE:    mode_q    <= cfg_data_i[1:0];
        CFG_LIMIT_CURRENT: lim_q     <= cfg_data_i[14:0];
        CFG_SAFE_CURRENT:  safe_q    <= cfg_data_i[14:0];
        CFG_SYS_RES:       sysres_q  <= cfg_data_i[15:0];
        CFG_DIODE_VOLTAGE: diode_q   <= cfg_data_i[11:0];
        CFG_REDUCED_PORT:  reduced_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_mag   = cur_q[15] ? (17'd0 - {cur_q[15], cur_q}) : {1'b0, cur_q};
    cur_mag10 = 21'(cur_mag) * 21'd10;
    lim9      = 21'(lim_q) * 21'd9;

    tgt      = cmd_i.sel_safe ? safe_q : lim_q;
    rsum     = 17'(res_q) + 17'(sysres_q);
    prod_d   = 32'(tgt) * 32'(rsum);
    bd_sum   = 16'(batt_q) + 16'(diode_q);
    den_d    = 26'(bd_sum) * 26'd1000;

    drop     = 34'(prod_q) + 34'(diode_q) * 34'd1000;
    bemf_k   = {{20{bemf_q[15]}}, bemf_q} * 36'sd1000;
    drop_s   = $signed({2'b00, drop});
    // Forward drive adds the drop, reverse drive subtracts it
    num_d    = pcmd_q[7] ? (bemf_k - drop_s) : (bemf_k + drop_s);

    abs_num  = num_q[35] ? 35'(36'd0 - num_q) : 35'(num_q);
    mag_d    = {abs_num, 7'd0} - 42'(abs_num);

    red_prod = 14'(q_q) * 14'd90;
    q_ext    = {1'b0, q_q};

    q_d = q_q;
    if (rem_q >= 33'(dsh_q)) begin
      q_d = {q_q[5:0], 1'b1};
    end else begin
      q_d = {q_q[5:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        cur_q  <= item_i.current_filtered;
        bemf_q <= item_i.back_emf;
        res_q  <= item_i.winding_resistance;
        batt_q <= item_i.battery_voltage;
        rpm_q  <= item_i.rpm;
        pcmd_q <= item_i.present_command;
        ptc_q  <= item_i.ptc_tripped;
        bank_q <= item_i.bank_ptc_tripped;
      end
      DP_MUL: begin
        prod_q <= prod_d;
        den_q  <= den_d;
      end
      DP_NUM: begin
        num_q <= num_d;
      end
      DP_SCALE: begin
        mag_q <= mag_d;
        neg_q <= num_q[35];
      end
      DP_DIV_INIT: begin
        // Quotient is known to be below 128, so seven steps suffice
        rem_q  <= mag_q[32:0];
        dsh_q  <= {den_q, 6'd0};
        q_q    <= '0;
        sign_q <= neg_q;
      end
      DP_DIV_STEP: begin
        if (rem_q >= 33'(dsh_q)) begin
          rem_q <= rem_q - 33'(dsh_q);
        end
        q_q   <= q_d;
        dsh_q <= dsh_q >> 1;
      end
      DP_SET_ZERO: begin
        q_q    <= '0;
        sign_q <= 1'b0;
      end
      DP_SET_MAX: begin
        q_q    <= CMD_MAG_MAX;
        sign_q <= cmd_i.neg;
      end
      DP_REDUCE: begin
        if (reduced_q) begin
          q_q <= red_prod[13:7];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_limit_q <= '0;
      held_nl_q    <= 1'b1;
    end else begin
      case (cmd_i.op)
        DP_STORE_LIMIT: begin
          held_limit_q <= sign_q ? $signed(8'd0 - q_ext) : $signed(q_ext);
          held_nl_q    <= 1'b0;
        end
        DP_STORE_NOLIMIT: begin
          held_limit_q <= '0;
          held_nl_q    <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.mode        = mode_q;
    stat_o.mag_gt      = cur_mag > {2'b00, lim_q};
    stat_o.mag_lt_hyst = cur_mag10 < lim9;
    stat_o.lim_zero    = (lim_q == '0);
    stat_o.safe_zero   = (safe_q == '0);
    stat_o.cmd_neg     = pcmd_q[7];
    stat_o.rpm_neg     = rpm_q[15];
    stat_o.rpm_pos     = !rpm_q[15] && (rpm_q != '0);
    stat_o.ptc         = ptc_q;
    stat_o.bank        = bank_q;
    stat_o.num_zero    = (mag_q == '0);
    stat_o.num_neg     = neg_q;
    stat_o.sat         = mag_q >= 42'({den_q, 7'd0});
  end

  assign limit_o    = held_limit_q;
  assign no_limit_o = held_nl_q;

endmodule

/* rtl/core/mccl_ctrl.sv */
module mccl_ctrl import mccl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic     trip_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e          state_q, state_d;
  logic            trip_q;
  logic            sel_safe_q;
  logic            out_valid_q;
  logic [CntW-1:0] cnt_q;

  logic slot_free;
  logic trip_new;
  logic want_calc;
  logic hold;
  logic sel;
  logic tgt_zero;
  logic mis_pos;
  logic mis_neg;

  // Decision for the item in DECIDE
  always_comb begin
    slot_free = !out_valid_q || out_ready_i;
    trip_new  = trip_q;
    want_calc = 1'b0;
    hold      = 1'b0;
    sel       = 1'b0;
    case (stat_i.mode)
      MODE_CURRENT: begin
        trip_new  = trip_q ? !stat_i.mag_lt_hyst : stat_i.mag_gt;
        want_calc = trip_new;
      end
      MODE_FUSE: begin
        hold      = stat_i.bank;
        want_calc = !stat_i.bank && stat_i.ptc;
        sel       = 1'b1;
      end
      default: ;
    endcase
    tgt_zero = sel ? stat_i.safe_zero : stat_i.lim_zero;
    mis_pos  = !stat_i.cmd_neg && stat_i.rpm_neg;
    mis_neg  = stat_i.cmd_neg && stat_i.rpm_pos;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (slot_free) begin
          if (!want_calc) begin
            state_d = ST_IDLE;
          end else if (tgt_zero || mis_pos || mis_neg) begin
            state_d = ST_REDUCE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL:   state_d = ST_NUM;
      ST_NUM:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_CMP;
      ST_CMP: begin
        if (stat_i.num_zero || stat_i.sat) begin
          state_d = ST_REDUCE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: state_d = ST_STORE;
      ST_STORE:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.op     = DP_NONE;
    cmd_o.sel_safe = sel_safe_q;
    cmd_o.neg    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
        end
      end
      ST_DECIDE: begin
        if (slot_free) begin
          if (!want_calc) begin
            cmd_o.op = hold ? DP_NONE : DP_STORE_NOLIMIT;
          end else if (tgt_zero) begin
            cmd_o.op = DP_SET_ZERO;
          end else if (mis_pos || mis_neg) begin
            cmd_o.op  = DP_SET_MAX;
            cmd_o.neg = mis_neg;
          end
        end
      end
      ST_MUL:   cmd_o.op = DP_MUL;
      ST_NUM:   cmd_o.op = DP_NUM;
      ST_SCALE: cmd_o.op = DP_SCALE;
      ST_CMP: begin
        if (stat_i.num_zero) begin
          cmd_o.op = DP_SET_ZERO;
        end else if (stat_i.sat) begin
          cmd_o.op  = DP_SET_MAX;
          cmd_o.neg = stat_i.num_neg;
        end else begin
          cmd_o.op = DP_DIV_INIT;
        end
      end
      ST_DIV:    cmd_o.op = DP_DIV_STEP;
      ST_REDUCE: cmd_o.op = DP_REDUCE;
      ST_STORE:  cmd_o.op = DP_STORE_LIMIT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      trip_q      <= 1'b0;
      sel_safe_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DECIDE && slot_free) begin
        trip_q     <= trip_new;
        sel_safe_q <= sel;
      end
      if (state_q == ST_CMP) begin
        cnt_q <= '0;
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      // Raise valid with the held limit; drop it once the beat is taken
      if ((state_q == ST_DECIDE && slot_free && !want_calc) || state_q == ST_STORE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign trip_o      = trip_q;

endmodule

/* rtl/core/motor_current_command_limiter.sv */
// Motor current command limiter: each accepted beat is one motor update and
// yields exactly one result beat with the command limit, the no-limit flag
// and the current-trip state. A beat that needs no safe command (no limit,
// fuse hold, untripped) gives its result from the decision state; a zero
// target or a polarity mismatch goes through reduce and store, a computed
// safe command through multiply, numerator, scale, compare, the restoring
// divider that forms one quotient bit per cycle, reduce and store, and skips
// the divider when the numerator is zero or the quotient clips. One update
// is in flight at a time; the next beat is taken in idle, reached as the
// previous result is registered. The result sits in an output register,
// and the next beat is accepted while it waits. Configuration writes take
// effect at once and should be made while the block is idle.
module motor_current_command_limiter import mccl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  mccl_in_if.sink             in_i,
  mccl_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic signed [7:0] limit;
  logic              no_limit;
  logic              trip;
  logic              in_ready;
  logic              out_valid;

  mccl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .trip_o      (trip),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mccl_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (in_i.data),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .limit_o    (limit),
    .no_limit_o (no_limit)
  );

  assign in_i.ready                = in_ready;
  assign out_o.valid               = out_valid;
  assign out_o.data.command_limit  = limit;
  assign out_o.data.no_limit       = no_limit;
  assign out_o.data.trip_flag      = trip;

endmodule
